// ===== src/rotated_pattern_stamp_defines.svh =====
// assertion macros for the rotated pattern stamp
`ifndef ROTATED_PATTERN_STAMP_DEFINES_SVH
`define ROTATED_PATTERN_STAMP_DEFINES_SVH

`ifndef SYNTH
// checked property, muted while in reset
`define RPS_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// checked property, live during reset as well
`define RPS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define RPS_ASSERT(lbl, ck, rn, prop, msg)
`define RPS_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ===== src/rps_pkg.sv =====
// shared types and constants for the rotated pattern stamp
package rps_pkg;

    localparam int FIELD_DIM_DEF   = 64;
    localparam int PATTERN_DIM_DEF = 8;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    localparam logic [6:0] FIELD_WIDTH_RST    = 7'd64;
    localparam logic [6:0] FIELD_HEIGHT_RST   = 7'd64;
    localparam logic [3:0] PATTERN_WIDTH_RST  = 4'd8;
    localparam logic [3:0] PATTERN_HEIGHT_RST = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD_PAT   = 2'd0,
        OP_WRITE_CELL = 2'd1,
        OP_STAMP      = 2'd2,
        OP_NOP        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        CFG_FIELD_WIDTH    = 2'd0,
        CFG_FIELD_HEIGHT   = 2'd1,
        CFG_PATTERN_WIDTH  = 2'd2,
        CFG_PATTERN_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_WR,
        ST_ROW,
        ST_LOAD,
        ST_CELL,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t        operation;
        logic [2:0] pattern_row;
        logic [2:0] pattern_col;
        logic [5:0] field_x;
        logic [5:0] field_y;
        logic       cell_value;
        logic [5:0] origin_x;
        logic [5:0] origin_y;
        rot_t       rotation;
    } item_t;

    typedef struct packed {
        logic [5:0] set_x;
        logic [5:0] set_y;
        logic       newly_set;
        logic       last;
    } res_t;

    // clip bounds; pattern sizes already limited to the store size
    typedef struct packed {
        logic [6:0] fw;
        logic [6:0] fh;
        logic [3:0] pw;
        logic [3:0] ph;
    } geom_t;

    typedef struct packed {
        logic       en;
        logic [2:0] row;
        logic [2:0] col;
        logic       val;
    } pat_write_t;

    typedef struct packed {
        rot_t       rot;
        logic [3:0] dx;
        logic [3:0] dy;
        logic [3:0] pw;
        logic [3:0] ph;
    } pat_lookup_t;

endpackage

// ===== src/rps_ram.sv =====
// generic simple dual port ram with registered read
module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rps_pattern.sv =====
// pattern register file with rotated bit lookup
module rps_pattern #(
    parameter int PATTERN_DIM = rps_pkg::PATTERN_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rps_pkg::pat_write_t wr,
    input  rps_pkg::pat_lookup_t lk,
    output logic                bit_out
);

    localparam int PAW = (PATTERN_DIM > 1) ? $clog2(PATTERN_DIM) : 1;
    localparam logic [3:0] PD = 4'(PATTERN_DIM);

    logic [PATTERN_DIM-1:0] pat_reg [PATTERN_DIM];
    logic [3:0]             r;
    logic [3:0]             c;
    logic                   ok;
    logic                   wr_ok;

    assign wr_ok = wr.en && ({1'b0, wr.row} < PD) && ({1'b0, wr.col} < PD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_DIM; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (wr_ok)
        begin
            pat_reg[wr.row[PAW-1:0]][wr.col[PAW-1:0]] <= wr.val;
        end
    end

    always_comb
    begin
        r  = lk.dy;
        c  = lk.dx;
        ok = 1'b0;
        unique case (lk.rot)
            rps_pkg::ROT_0:
            begin
                ok = (lk.dx < lk.pw) && (lk.dy < lk.ph);
                r  = lk.dy;
                c  = lk.dx;
            end
            rps_pkg::ROT_90:
            begin
                ok = (lk.dx < lk.ph) && (lk.dy < lk.pw);
                r  = lk.ph - 4'd1 - lk.dx;
                c  = lk.dy;
            end
            rps_pkg::ROT_180:
            begin
                ok = (lk.dx < lk.pw) && (lk.dy < lk.ph);
                r  = lk.ph - 4'd1 - lk.dy;
                c  = lk.pw - 4'd1 - lk.dx;
            end
            rps_pkg::ROT_270:
            begin
                ok = (lk.dx < lk.ph) && (lk.dy < lk.pw);
                r  = lk.dx;
                c  = lk.pw - 4'd1 - lk.dy;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        ok      = ok && (r < PD) && (c < PD);
        bit_out = ok && pat_reg[r[PAW-1:0]][c[PAW-1:0]];
    end

endmodule

// ===== src/rps_seq.sv =====
// sequencer: field row read-modify-write, result ordering and output register
`include "rotated_pattern_stamp_defines.svh"

module rps_seq #(
    parameter int FIELD_DIM = rps_pkg::FIELD_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  rps_pkg::item_t                    item,
    input  rps_pkg::geom_t                    geom,
    output rps_pkg::pat_write_t               pat_wr,
    output rps_pkg::pat_lookup_t              pat_lk,
    input  logic                              pat_bit,
    output logic                              ram_we,
    output logic [$clog2(FIELD_DIM)-1:0]      ram_waddr,
    output logic [FIELD_DIM-1:0]              ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(FIELD_DIM)-1:0]      ram_raddr,
    input  logic [FIELD_DIM-1:0]              ram_rdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output rps_pkg::res_t                     res
);

    localparam int AW = $clog2(FIELD_DIM);
    localparam int CW = (AW > 7) ? AW : 7;
    localparam logic [CW:0]   FD       = (CW+1)'(FIELD_DIM);
    localparam logic [AW-1:0] CLR_LAST = AW'(FIELD_DIM - 1);

    rps_pkg::state_t state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [CW-1:0]        ox_reg, ox_next;
    logic [CW-1:0]        oy_reg, oy_next;
    rps_pkg::rot_t        rot_reg, rot_next;
    logic [3:0]           dx_reg, dx_next;
    logic [3:0]           dy_reg, dy_next;
    logic [FIELD_DIM-1:0] row_reg, row_next;
    logic [CW-1:0]        wr_x_reg, wr_x_next;
    logic [AW-1:0]        wr_row_reg, wr_row_next;
    logic                 wr_val_reg, wr_val_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [5:0]           pend_x_reg, pend_x_next;
    logic [5:0]           pend_y_reg, pend_y_next;
    logic                 out_valid_reg, out_valid_next;
    rps_pkg::res_t        out_res_reg, out_res_next;

    logic [3:0]           span;
    logic [CW-1:0]        x;
    logic [CW-1:0]        y;
    logic [CW-1:0]        fx_c;
    logic [CW-1:0]        fy_c;
    logic                 x_ok;
    logic                 row_ok;
    logic                 cell_ok;
    logic                 hit;
    logic                 out_free;
    logic [FIELD_DIM-1:0] cell_row;

    assign span     = (geom.pw > geom.ph) ? geom.pw : geom.ph;
    assign x        = ox_reg + CW'(dx_reg);
    assign y        = oy_reg + CW'(dy_reg);
    assign fx_c     = CW'(item.field_x);
    assign fy_c     = CW'(item.field_y);
    assign x_ok     = (dx_reg < span) && (x < CW'(geom.fw)) && ({1'b0, x} < FD);
    assign row_ok   = (dy_reg < span) && (y < CW'(geom.fh)) && ({1'b0, y} < FD);
    assign cell_ok  = ({1'b0, fx_c} < FD) && ({1'b0, fy_c} < FD);
    assign hit      = pat_bit && !row_reg[x[AW-1:0]];
    assign out_free = !out_valid_reg || m_tready;

    assign pat_lk.rot = rot_reg;
    assign pat_lk.dx  = dx_reg;
    assign pat_lk.dy  = dy_reg;
    assign pat_lk.pw  = geom.pw;
    assign pat_lk.ph  = geom.ph;

    always_comb
    begin
        cell_row                     = ram_rdata;
        cell_row[wr_x_reg[AW-1:0]]   = wr_val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rps_pkg::ST_CLEAR;
            clr_reg        <= '0;
            ox_reg         <= '0;
            oy_reg         <= '0;
            rot_reg        <= rps_pkg::ROT_0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            row_reg        <= '0;
            wr_x_reg       <= '0;
            wr_row_reg     <= '0;
            wr_val_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_x_reg     <= '0;
            pend_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            ox_reg         <= ox_next;
            oy_reg         <= oy_next;
            rot_reg        <= rot_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            row_reg        <= row_next;
            wr_x_reg       <= wr_x_next;
            wr_row_reg     <= wr_row_next;
            wr_val_reg     <= wr_val_next;
            pend_valid_reg <= pend_valid_next;
            pend_x_reg     <= pend_x_next;
            pend_y_reg     <= pend_y_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        rot_next        = rot_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        row_next        = row_reg;
        wr_x_next       = wr_x_reg;
        wr_row_next     = wr_row_reg;
        wr_val_next     = wr_val_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_res_next    = out_res_reg;

        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = y[AW-1:0];
        pat_wr.en  = 1'b0;
        pat_wr.row = item.pattern_row;
        pat_wr.col = item.pattern_col;
        pat_wr.val = item.cell_value;

        unique case (state_reg)
            rps_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = rps_pkg::ST_IDLE;
                end
            end

            rps_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (item.operation)
                        rps_pkg::OP_LOAD_PAT:
                        begin
                            pat_wr.en = 1'b1;
                        end
                        rps_pkg::OP_WRITE_CELL:
                        begin
                            if (cell_ok)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = fy_c[AW-1:0];
                                wr_x_next   = fx_c;
                                wr_row_next = fy_c[AW-1:0];
                                wr_val_next = item.cell_value;
                                state_next  = rps_pkg::ST_CELL_WR;
                            end
                        end
                        rps_pkg::OP_STAMP:
                        begin
                            ox_next    = CW'(item.origin_x);
                            oy_next    = CW'(item.origin_y);
                            rot_next   = item.rotation;
                            dy_next    = '0;
                            state_next = rps_pkg::ST_ROW;
                        end
                        rps_pkg::OP_NOP:
                        begin
                            state_next = rps_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            state_next = rps_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            rps_pkg::ST_CELL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_row_reg;
                ram_wdata  = cell_row;
                state_next = rps_pkg::ST_IDLE;
            end

            rps_pkg::ST_ROW:
            begin
                if (row_ok)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = y[AW-1:0];
                    state_next = rps_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = rps_pkg::ST_DONE;
                end
            end

            rps_pkg::ST_LOAD:
            begin
                row_next   = ram_rdata;
                dx_next    = '0;
                state_next = rps_pkg::ST_CELL;
            end

            rps_pkg::ST_CELL:
            begin
                if (x_ok)
                begin
                    // a new hit pushes the held one out, so wait for a free slot
                    if (!(hit && pend_valid_reg && !out_free))
                    begin
                        if (pat_bit)
                        begin
                            row_next[x[AW-1:0]] = 1'b1;
                        end
                        if (hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next         = 1'b1;
                                out_res_next.set_x     = pend_x_reg;
                                out_res_next.set_y     = pend_y_reg;
                                out_res_next.newly_set = 1'b1;
                                out_res_next.last      = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_x_next     = x[5:0];
                            pend_y_next     = y[5:0];
                        end
                        dx_next = dx_reg + 4'd1;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = y[AW-1:0];
                    ram_wdata  = row_reg;
                    dy_next    = dy_reg + 4'd1;
                    state_next = rps_pkg::ST_ROW;
                end
            end

            rps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_res_next.set_x     = pend_valid_reg ? pend_x_reg : 6'd0;
                    out_res_next.set_y     = pend_valid_reg ? pend_y_reg : 6'd0;
                    out_res_next.newly_set = pend_valid_reg;
                    out_res_next.last      = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = rps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rps_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_res_reg;

    `RPS_ASSERT(a_empty_is_last, clk, rst_n, (m_tvalid && !res.newly_set) |-> res.last, "empty stamp word without last")
    `RPS_ASSERT(a_pend_in_stamp, clk, rst_n, pend_valid_reg |-> (state_reg == rps_pkg::ST_ROW || state_reg == rps_pkg::ST_LOAD || state_reg == rps_pkg::ST_CELL || state_reg == rps_pkg::ST_DONE), "held report outside a stamp")
    `RPS_ASSERT_ALWAYS(a_no_rw_clash, clk, !(ram_we && ram_re && ram_waddr == ram_raddr), "field row read and written in one cycle")
    `RPS_ASSERT(a_done_flushes, clk, rst_n, (state_reg == rps_pkg::ST_DONE && out_free) |=> (m_tvalid && res.last && !pend_valid_reg), "stamp end did not flush the held report")

endmodule

// ===== src/rotated_pattern_stamp.sv =====
// top level of the rotated pattern stamp
//
// channel  dir  handshake          contents
// s_*      in   tvalid/tready      tdata: operation[1:0] pattern_row[4:2] pattern_col[7:5]
//                                  field_x[13:8] field_y[19:14] cell_value[20]
//                                  origin_x[26:21] origin_y[32:27] rotation[34:33]
// m_*      out  tvalid/tready      tdata: set_x[5:0] set_y[11:6]; tuser newly_set; tlast last
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data holds the value
//
// load pattern bit is one register write; write field cell is a row read, then a row write
// a stamp does one field ram row read and one write back per clipped row and visits
// one cell per cycle while no new report waits on a held output word
// after reset a clearing pass writes zeros over FIELD_DIM rows, one row a cycle, s_tready low
// a stamp stalls on a new report while the output word is held by m_tready
module rotated_pattern_stamp #(
    parameter int FIELD_DIM   = rps_pkg::FIELD_DIM_DEF,
    parameter int PATTERN_DIM = rps_pkg::PATTERN_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation, pattern_row, pattern_col, field_x, field_y, cell_value,
    // origin_x, origin_y, rotation
    input  logic [rps_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // set_x, set_y
    output logic [rps_pkg::M_TDATA_W-1:0]     m_tdata,
    // newly_set
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [rps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(FIELD_DIM);
    localparam logic [3:0] PD = 4'(PATTERN_DIM);

    logic [6:0] field_width_reg;
    logic [6:0] field_height_reg;
    logic [3:0] pattern_width_reg;
    logic [3:0] pattern_height_reg;

    rps_pkg::item_t       item;
    rps_pkg::geom_t       geom;
    rps_pkg::pat_write_t  pat_wr;
    rps_pkg::pat_lookup_t pat_lk;
    rps_pkg::res_t        res;
    logic                 pat_bit;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [FIELD_DIM-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [FIELD_DIM-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg    <= rps_pkg::FIELD_WIDTH_RST;
            field_height_reg   <= rps_pkg::FIELD_HEIGHT_RST;
            pattern_width_reg  <= rps_pkg::PATTERN_WIDTH_RST;
            pattern_height_reg <= rps_pkg::PATTERN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (rps_pkg::cfg_idx_t'(cfg_index))
                rps_pkg::CFG_FIELD_WIDTH:    field_width_reg    <= cfg_data;
                rps_pkg::CFG_FIELD_HEIGHT:   field_height_reg   <= cfg_data;
                rps_pkg::CFG_PATTERN_WIDTH:  pattern_width_reg  <= cfg_data[3:0];
                rps_pkg::CFG_PATTERN_HEIGHT: pattern_height_reg <= cfg_data[3:0];
                default:                     field_width_reg    <= field_width_reg;
            endcase
        end
    end

    // field bounds against FIELD_DIM are applied in the sequencer
    assign geom.fw = field_width_reg;
    assign geom.fh = field_height_reg;
    assign geom.pw = (pattern_width_reg > PD) ? PD : pattern_width_reg;
    assign geom.ph = (pattern_height_reg > PD) ? PD : pattern_height_reg;

    assign item.operation   = rps_pkg::op_t'(s_tdata[1:0]);
    assign item.pattern_row = s_tdata[4:2];
    assign item.pattern_col = s_tdata[7:5];
    assign item.field_x     = s_tdata[13:8];
    assign item.field_y     = s_tdata[19:14];
    assign item.cell_value  = s_tdata[20];
    assign item.origin_x    = s_tdata[26:21];
    assign item.origin_y    = s_tdata[32:27];
    assign item.rotation    = rps_pkg::rot_t'(s_tdata[34:33]);

    rps_pattern #(
        .PATTERN_DIM(PATTERN_DIM)
    ) u_pattern (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pat_wr),
        .lk      (pat_lk),
        .bit_out (pat_bit)
    );

    rps_ram #(
        .WIDTH(FIELD_DIM),
        .DEPTH(FIELD_DIM)
    ) u_field_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rps_seq #(
        .FIELD_DIM(FIELD_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .item      (item),
        .geom      (geom),
        .pat_wr    (pat_wr),
        .pat_lk    (pat_lk),
        .pat_bit   (pat_bit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    assign m_tdata = {4'b0000, res.set_y, res.set_x};
    assign m_tuser = res.newly_set;
    assign m_tlast = res.last;

endmodule

// ===== tb/tb_rotated_pattern_stamp.sv =====
// testbench for the rotated pattern stamp: directed and random command streams checked per report
`timescale 1ns / 1ps

module tb_rotated_pattern_stamp;
    import rps_pkg::*;

    // tracks pattern and field contents and the reports each stamp must produce
    class stamp_scoreboard;
        bit   pat_bits [8][8];
        bit   cells [64][64];
        int   fw;
        int   fh;
        int   pw;
        int   ph;
        res_t reports_q [$];
        int   errors;

        function new();
            fw = FIELD_WIDTH_RST;
            fh = FIELD_HEIGHT_RST;
            pw = PATTERN_WIDTH_RST;
            ph = PATTERN_HEIGHT_RST;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [6:0] v);
            case (idx)
                CFG_FIELD_WIDTH:    fw = v;
                CFG_FIELD_HEIGHT:   fh = v;
                CFG_PATTERN_WIDTH:  pw = v[3:0];
                CFG_PATTERN_HEIGHT: ph = v[3:0];
                default: ;
            endcase
        endfunction

        // pattern bit under offset (dx, dy) after rotation, 0 outside the rotated box
        function bit rotated_bit(rot_t rot, int dx, int dy, int w, int h);
            int r;
            int c;
            case (rot)
                ROT_0:
                begin
                    if (dx >= w || dy >= h) return 1'b0;
                    r = dy;
                    c = dx;
                end
                ROT_90:
                begin
                    if (dx >= h || dy >= w) return 1'b0;
                    r = h - 1 - dx;
                    c = dy;
                end
                ROT_180:
                begin
                    if (dx >= w || dy >= h) return 1'b0;
                    r = h - 1 - dy;
                    c = w - 1 - dx;
                end
                default:
                begin
                    if (dx >= h || dy >= w) return 1'b0;
                    r = dx;
                    c = w - 1 - dy;
                end
            endcase
            if (r < 0 || r > 7 || c < 0 || c > 7) return 1'b0;
            return pat_bits[r][c];
        endfunction

        function void stamp_pattern(int ox, int oy, rot_t rot);
            int   w;
            int   h;
            int   fwc;
            int   fhc;
            int   span;
            int   n;
            int   x;
            int   y;
            res_t r;
            w = (pw > 8) ? 8 : pw;
            h = (ph > 8) ? 8 : ph;
            fwc = (fw > 64) ? 64 : fw;
            fhc = (fh > 64) ? 64 : fh;
            span = (w > h) ? w : h;
            n = 0;
            for (int dy = 0; dy < span; dy++)
            begin
                y = oy + dy;
                if (y >= fhc) break;
                for (int dx = 0; dx < span; dx++)
                begin
                    x = ox + dx;
                    if (x >= fwc) break;
                    if (!rotated_bit(rot, dx, dy, w, h)) continue;
                    if (!cells[y][x] && n < 64)
                    begin
                        r.set_x = x[5:0];
                        r.set_y = y[5:0];
                        r.newly_set = 1'b1;
                        r.last = 1'b0;
                        reports_q.push_back(r);
                        n++;
                    end
                    cells[y][x] = 1'b1;
                end
            end
            if (n == 0)
            begin
                r = '0;
                r.last = 1'b1;
                reports_q.push_back(r);
            end
            else
                reports_q[reports_q.size() - 1].last = 1'b1;
        endfunction

        function void note_input(item_t it);
            case (it.operation)
                OP_LOAD_PAT:   pat_bits[it.pattern_row][it.pattern_col] = it.cell_value;
                OP_WRITE_CELL: cells[it.field_y][it.field_x] = it.cell_value;
                OP_STAMP:      stamp_pattern(it.origin_x, it.origin_y, it.rotation);
                default: ;
            endcase
        endfunction

        function void check_result(logic [5:0] x, logic [5:0] y, logic ns, logic lst);
            res_t e;
            if (reports_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report x=%0d y=%0d new=%0d last=%0d",
                         $time, x, y, ns, lst);
                return;
            end
            e = reports_q.pop_front();
            if (e.set_x !== x || e.set_y !== y || e.newly_set !== ns || e.last !== lst)
            begin
                errors++;
                $display("%0t: report mismatch: expected x=%0d y=%0d new=%0d last=%0d,",
                         $time, e.set_x, e.set_y, e.newly_set, e.last,
                         " got x=%0d y=%0d new=%0d last=%0d", x, y, ns, lst);
            end
        endfunction

        function int pending();
            return reports_q.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    stamp_scoreboard sb = new();
    bit hold_start = 1'b0;
    bit src_calm = 1'b0;

    // field and pattern sizes for the random phases
    int ph_fw [7] = '{64, 16, 1, 127, 10, 33, 8};
    int ph_fh [7] = '{64, 12, 1, 127, 40, 64, 8};
    int ph_pw [7] = '{8, 5, 1, 15, 8, 3, 8};
    int ph_ph [7] = '{8, 3, 1, 15, 2, 7, 8};

    rotated_pattern_stamp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(item_t it);
        return {5'b0, it.rotation, it.origin_y, it.origin_x, it.cell_value, it.field_y,
                it.field_x, it.pattern_col, it.pattern_row, it.operation};
    endfunction

    function automatic item_t rand_fields(op_t op);
        item_t       it;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        it.operation = op;
        it.pattern_row = a[2:0];
        it.pattern_col = a[5:3];
        it.field_x = a[11:6];
        it.field_y = a[17:12];
        it.cell_value = a[18];
        it.origin_x = a[24:19];
        it.origin_y = a[30:25];
        it.rotation = rot_t'(b[1:0]);
        return it;
    endfunction

    // mostly commands that land inside the active field, cell writes mostly clear
    function automatic item_t rand_item();
        item_t       it;
        int          pick;
        int          xb;
        int          yb;
        logic [31:0] z;
        pick = $urandom_range(99, 0);
        xb = (sb.fw > 64 || sb.fw == 0) ? 64 : sb.fw;
        yb = (sb.fh > 64 || sb.fh == 0) ? 64 : sb.fh;
        if (pick < 24)
        begin
            it = rand_fields(OP_LOAD_PAT);
            it.cell_value = ($urandom_range(99, 0) < 65);
        end
        else if (pick < 54)
        begin
            it = rand_fields(OP_WRITE_CELL);
            if ($urandom_range(99, 0) < 85)
            begin
                z = $urandom_range(xb - 1, 0);
                it.field_x = z[5:0];
                z = $urandom_range(yb - 1, 0);
                it.field_y = z[5:0];
            end
            it.cell_value = ($urandom_range(99, 0) < 20);
        end
        else if (pick < 95)
        begin
            it = rand_fields(OP_STAMP);
            if ($urandom_range(99, 0) < 85)
            begin
                z = $urandom_range(xb - 1, 0);
                it.origin_x = z[5:0];
                z = $urandom_range(yb - 1, 0);
                it.origin_y = z[5:0];
            end
        end
        else
            it = rand_fields(OP_NOP);
        return it;
    endfunction

    task automatic send_item(item_t it);
        while (!src_calm && $urandom_range(99, 0) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_word(it);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic do_load(int r, int c, bit v);
        item_t it;
        it = rand_fields(OP_LOAD_PAT);
        it.pattern_row = r[2:0];
        it.pattern_col = c[2:0];
        it.cell_value = v;
        send_item(it);
    endtask

    task automatic do_cell(int x, int y, bit v);
        item_t it;
        it = rand_fields(OP_WRITE_CELL);
        it.field_x = x[5:0];
        it.field_y = y[5:0];
        it.cell_value = v;
        send_item(it);
    endtask

    task automatic do_stamp(int x, int y, rot_t rot);
        item_t it;
        it = rand_fields(OP_STAMP);
        it.origin_x = x[5:0];
        it.origin_y = y[5:0];
        it.rotation = rot;
        send_item(it);
    endtask

    task automatic write_reg(cfg_idx_t idx, int v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[6:0];
        @(posedge clk);
        sb.set_reg(idx, v[6:0]);
    endtask

    task automatic set_geometry(int fw, int fh, int pw, int ph);
        write_reg(CFG_FIELD_WIDTH, fw);
        write_reg(CFG_FIELD_HEIGHT, fh);
        write_reg(CFG_PATTERN_WIDTH, pw);
        write_reg(CFG_PATTERN_HEIGHT, ph);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // a trailing cell write gives no report, so leave room for a full stamp after the last one
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // report sink with random stalls, one long hold-off and periodic stall-free windows
    initial
    begin
        int  cyc;
        int  hold_left;
        bit  hold_used;
        cyc = 0;
        hold_left = 0;
        hold_used = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[5:0], m_tdata[11:6], m_tuser, m_tlast);
            if (hold_start && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if ((cyc % 3000) < 700)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99, 0) >= 12);
        end
    end

    initial
    begin
        item_t it;
        int    count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // asymmetric pattern so each rotation lands differently
        do_load(0, 0, 1'b1);
        do_load(7, 7, 1'b1);
        do_load(0, 7, 1'b1);
        do_load(7, 0, 1'b1);
        do_load(1, 2, 1'b1);
        do_load(3, 3, 1'b1);
        do_load(3, 3, 1'b0);
        do_stamp(0, 0, ROT_0);
        do_stamp(0, 0, ROT_0);
        do_cell(0, 0, 1'b0);
        do_cell(63, 63, 1'b1);
        do_stamp(0, 0, ROT_0);
        do_stamp(10, 0, ROT_90);
        do_stamp(20, 5, ROT_180);
        do_stamp(30, 10, ROT_270);
        do_stamp(60, 60, ROT_180);
        do_stamp(63, 56, ROT_90);
        send_item(rand_fields(OP_NOP));
        drain();

        // zero width clips everything, oversized pattern sizes saturate
        set_geometry(0, 127, 15, 15);
        do_stamp(5, 5, ROT_0);
        drain();
        set_geometry(127, 127, 15, 3);
        do_stamp(40, 40, ROT_90);
        do_stamp(0, 50, ROT_270);
        drain();
        set_geometry(64, 0, 8, 8);
        do_stamp(0, 0, ROT_180);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            set_geometry(ph_fw[p], ph_fh[p], ph_pw[p], ph_ph[p]);
            if (p == 0)
                hold_start = 1'b1;
            src_calm = (p == 4);
            count = 0;
            while (count < 61)
            begin
                it = rand_item();
                send_item(it);
                if (it.operation != OP_NOP)
                    count++;
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #6ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== rotated_pattern_stamp.f =====
+incdir+src
src/rps_pkg.sv
src/rps_ram.sv
src/rps_pattern.sv
src/rps_seq.sv
src/rotated_pattern_stamp.sv
tb/tb_rotated_pattern_stamp.sv
